// ===== hw/rtl/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, types and constants of the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    localparam int NUM_ELEMS = 9;
    localparam int PROD_W    = 2 * DATA_WIDTH;            // element product
    localparam int ADJ_W     = PROD_W + 1;                // cofactor
    localparam int DETP_W    = DATA_WIDTH + ADJ_W;        // element * cofactor
    localparam int DET_W     = DETP_W + 2;                // sum of three
    localparam int NUM_W     = ADJ_W + 2 * FRAC_BITS;     // scaled numerator
    localparam int QUO_W     = DATA_WIDTH + 1;            // quotient bits kept
    localparam int NUMHI_W   = NUM_W - QUO_W;
    localparam int WIDE_W    = NUM_W + DET_W;             // compare width
    localparam int REM_W     = DET_W;

    localparam int COF_LAT  = 4;
    localparam int LANE_LAT = QUO_W + 2;
    localparam int PIPE_LAT = COF_LAT + LANE_LAT;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef logic signed [ADJ_W-1:0]      adj_t;

    typedef struct packed {
        logic [DET_W-1:0] dmag;
        logic             neg;
        logic             zero;
    } det_info_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  ovf;
    } lane_res_t;

endpackage

// ===== hw/rtl/m3i_cofactor.sv =====
// ----------------------------------------------------------------------------
// m3i_cofactor
// Four-stage pipeline: cofactor products, cofactors, determinant terms,
// determinant sum with magnitude, sign and zero test.
// ----------------------------------------------------------------------------
module m3i_cofactor (
    input  logic                  clk,
    input  logic                  en,
    input  m3i_pkg::elem_t        m [m3i_pkg::NUM_ELEMS],
    output m3i_pkg::adj_t         adj [m3i_pkg::NUM_ELEMS],
    output m3i_pkg::det_info_t    det
);

    logic signed [m3i_pkg::PROD_W-1:0] prod_a_reg [m3i_pkg::NUM_ELEMS];
    logic signed [m3i_pkg::PROD_W-1:0] prod_b_reg [m3i_pkg::NUM_ELEMS];
    m3i_pkg::adj_t                     adj_s2_reg [m3i_pkg::NUM_ELEMS];
    m3i_pkg::adj_t                     adj_s3_reg [m3i_pkg::NUM_ELEMS];
    m3i_pkg::adj_t                     adj_s4_reg [m3i_pkg::NUM_ELEMS];
    m3i_pkg::elem_t                    row0_s1_reg [3];
    m3i_pkg::elem_t                    row0_s2_reg [3];
    logic signed [m3i_pkg::DETP_W-1:0] term_reg [3];
    logic signed [m3i_pkg::DET_W-1:0]  det_sum;
    m3i_pkg::det_info_t                det_reg;
    m3i_pkg::det_info_t                det_next;

    // Form product pairs and cofactors per element
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int K  = i * 3 + j;
            localparam int I1 = (i + 1) % 3;
            localparam int I2 = (i + 2) % 3;
            localparam int J1 = (j + 1) % 3;
            localparam int J2 = (j + 2) % 3;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_a_reg[K] <= m[J1*3+I1] * m[J2*3+I2];
                    prod_b_reg[K] <= m[J1*3+I2] * m[J2*3+I1];
                    adj_s2_reg[K] <= m3i_pkg::ADJ_W'(prod_a_reg[K])
                                   - m3i_pkg::ADJ_W'(prod_b_reg[K]);
                    adj_s3_reg[K] <= adj_s2_reg[K];
                    adj_s4_reg[K] <= adj_s3_reg[K];
                end
            end
        end
    end

    // Carry row 0 and form the determinant terms
    for (genvar j = 0; j < 3; j++) begin : g_term
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                row0_s1_reg[j] <= m[j];
                row0_s2_reg[j] <= row0_s1_reg[j];
                term_reg[j]    <= m3i_pkg::DETP_W'(row0_s2_reg[j])
                                * m3i_pkg::DETP_W'(adj_s2_reg[j*3]);
            end
        end
    end

    // Sum the terms and split into magnitude and sign
    always_comb
    begin
        det_sum = m3i_pkg::DET_W'(term_reg[0]) + m3i_pkg::DET_W'(term_reg[1])
                + m3i_pkg::DET_W'(term_reg[2]);
        det_next.neg  = det_sum[m3i_pkg::DET_W-1];
        det_next.dmag = det_next.neg ? m3i_pkg::DET_W'(-det_sum) : det_sum;
        det_next.zero = (det_sum == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= det_next;
        end
    end

    assign adj = adj_s4_reg;
    assign det = det_reg;

endmodule

// ===== hw/rtl/m3i_div_lane.sv =====
// ----------------------------------------------------------------------------
// m3i_div_lane
// One inverse element: scaled cofactor over determinant, restoring division
// one quotient bit per stage, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module m3i_div_lane (
    input  logic                  clk,
    input  logic                  en,
    input  m3i_pkg::adj_t         adj,
    input  m3i_pkg::det_info_t    det,
    output m3i_pkg::lane_res_t    res
);

    localparam int QW = m3i_pkg::QUO_W;
    localparam int RW = m3i_pkg::REM_W;

    logic [m3i_pkg::ADJ_W-1:0]   adj_mag;
    logic [m3i_pkg::NUM_W-1:0]   num_mag;
    logic [m3i_pkg::NUMHI_W-1:0] num_hi;
    logic                        pre_ovf;

    logic [RW-1:0]               rem_reg  [QW+1];
    logic [QW-1:0]               quo_reg  [QW+1];
    logic [QW-1:0]               low_reg  [QW+1];
    logic [m3i_pkg::DET_W-1:0]   dmag_reg [QW+1];
    logic                        neg_reg  [QW+1];
    logic                        povf_reg [QW+1];

    logic                        round_up;
    logic [QW:0]                 quo_rnd;
    logic [QW:0]                 lim;
    logic                        sat;
    logic [QW:0]                 mag;
    m3i_pkg::lane_res_t          res_next;
    m3i_pkg::lane_res_t          res_reg;

    // Scale the numerator and test for a quotient beyond the kept bits
    always_comb
    begin
        adj_mag = adj[m3i_pkg::ADJ_W-1] ? m3i_pkg::ADJ_W'(-adj) : adj;
        num_mag = {adj_mag, {(2 * m3i_pkg::FRAC_BITS){1'b0}}};
        num_hi  = num_mag[m3i_pkg::NUM_W-1:QW];
        pre_ovf = m3i_pkg::WIDE_W'(num_hi) >= m3i_pkg::WIDE_W'(det.dmag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= RW'(num_hi);
            quo_reg[0]  <= '0;
            low_reg[0]  <= num_mag[QW-1:0];
            dmag_reg[0] <= det.dmag;
            neg_reg[0]  <= adj[m3i_pkg::ADJ_W-1] ^ det.neg;
            povf_reg[0] <= pre_ovf;
        end
    end

    // One restoring step per stage
    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [RW:0] trial;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[s], low_reg[s][QW-1]};
            ge    = trial >= {1'b0, dmag_reg[s]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= ge ? RW'(trial - {1'b0, dmag_reg[s]}) : RW'(trial);
                quo_reg[s+1]  <= {quo_reg[s][QW-2:0], ge};
                low_reg[s+1]  <= {low_reg[s][QW-2:0], 1'b0};
                dmag_reg[s+1] <= dmag_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                povf_reg[s+1] <= povf_reg[s];
            end
        end
    end

    // Round, saturate and apply the sign
    always_comb
    begin
        round_up = {rem_reg[QW], 1'b0} >= {1'b0, dmag_reg[QW]};
        quo_rnd  = {1'b0, quo_reg[QW]} + (QW+1)'(round_up);
        lim      = neg_reg[QW] ? (QW+1)'(1) << (m3i_pkg::DATA_WIDTH - 1)
                               : ((QW+1)'(1) << (m3i_pkg::DATA_WIDTH - 1)) - (QW+1)'(1);
        sat      = povf_reg[QW] || (quo_rnd > lim);
        mag      = sat ? lim : quo_rnd;
        res_next.value = neg_reg[QW] ? m3i_pkg::DATA_WIDTH'(-mag)
                                     : m3i_pkg::DATA_WIDTH'(mag);
        res_next.ovf   = sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/m3i_merge.sv =====
// ----------------------------------------------------------------------------
// m3i_merge
// Combine the nine lane results: OR the saturation flags and force zeros
// when the determinant was zero.
// ----------------------------------------------------------------------------
module m3i_merge (
    input  m3i_pkg::lane_res_t    lane [m3i_pkg::NUM_ELEMS],
    input  logic                  det_zero,
    output m3i_pkg::elem_t        inv [m3i_pkg::NUM_ELEMS],
    output logic                  singular,
    output logic                  overflow
);

    logic any_ovf;

    // Merge flags and zero out a singular result
    always_comb
    begin
        any_ovf = 1'b0;
        for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++)
        begin
            any_ovf = any_ovf | lane[k].ovf;
            inv[k]  = det_zero ? '0 : m3i_pkg::elem_t'(lane[k].value);
        end
        singular = det_zero;
        overflow = any_ovf & ~det_zero;
    end

endmodule

// ===== hw/rtl/matrix3x3_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Inverse of a signed Q3.12 3x3 matrix by the adjugate method.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one matrix per beat as nine
//   elements elem_rXcY. Output channel out_valid/out_ready carries the nine
//   inverse elements inv_rXcY, the singular flag and the overflow flag.
//   Each inverse element is rounded half away from zero and saturated to
//   16 bits; a zero determinant gives all zeros with singular set.
//   Throughput is one matrix per cycle while the receiver does not stall. The
//   accepting edge loads the first of 24 register stages: four
//   cofactor and determinant stages, a numerator stage, 17 restoring
//   division stages (one quotient bit each, nine lanes side by side), a
//   rounding stage and the output register.
//   Reset clears all valid bits; no item is in flight afterwards.
//   When the receiver stalls, the whole pipeline holds and in_ready drops
//   while a result waits in the output register; in_ready stays high while
//   the output register is empty or being drained.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            elem_r0c0,
    input  logic signed [15:0]            elem_r0c1,
    input  logic signed [15:0]            elem_r0c2,
    input  logic signed [15:0]            elem_r1c0,
    input  logic signed [15:0]            elem_r1c1,
    input  logic signed [15:0]            elem_r1c2,
    input  logic signed [15:0]            elem_r2c0,
    input  logic signed [15:0]            elem_r2c1,
    input  logic signed [15:0]            elem_r2c2,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            inv_r0c0,
    output logic signed [15:0]            inv_r0c1,
    output logic signed [15:0]            inv_r0c2,
    output logic signed [15:0]            inv_r1c0,
    output logic signed [15:0]            inv_r1c1,
    output logic signed [15:0]            inv_r1c2,
    output logic signed [15:0]            inv_r2c0,
    output logic signed [15:0]            inv_r2c1,
    output logic signed [15:0]            inv_r2c2,
    output logic                          singular,
    output logic                          overflow
);

    localparam int LL = m3i_pkg::LANE_LAT;
    localparam int PL = m3i_pkg::PIPE_LAT;

    logic                 en;
    m3i_pkg::elem_t       elems [m3i_pkg::NUM_ELEMS];
    m3i_pkg::adj_t        adj [m3i_pkg::NUM_ELEMS];
    m3i_pkg::det_info_t   det;
    m3i_pkg::lane_res_t   lane_res [m3i_pkg::NUM_ELEMS];
    logic [LL-1:0]        zero_reg;
    logic [PL-1:0]        vld_reg;
    logic [PL-1:0]        vld_next;
    m3i_pkg::elem_t       inv_next [m3i_pkg::NUM_ELEMS];
    logic                 sing_next;
    logic                 ovf_next;
    m3i_pkg::elem_t       inv_reg [m3i_pkg::NUM_ELEMS];
    logic                 sing_reg;
    logic                 ovf_reg;
    logic                 out_valid_reg;

    // Advance the pipeline whenever the output register can take a beat
    assign en       = ~out_valid_reg | out_ready;
    assign in_ready = en;

    assign elems[0] = elem_r0c0;
    assign elems[1] = elem_r0c1;
    assign elems[2] = elem_r0c2;
    assign elems[3] = elem_r1c0;
    assign elems[4] = elem_r1c1;
    assign elems[5] = elem_r1c2;
    assign elems[6] = elem_r2c0;
    assign elems[7] = elem_r2c1;
    assign elems[8] = elem_r2c2;

    m3i_cofactor u_cofactor (
        .clk (clk),
        .en  (en),
        .m   (elems),
        .adj (adj),
        .det (det)
    );

    for (genvar k = 0; k < m3i_pkg::NUM_ELEMS; k++) begin : g_lane
        m3i_div_lane u_lane (
            .clk (clk),
            .en  (en),
            .adj (adj[k]),
            .det (det),
            .res (lane_res[k])
        );
    end

    // Delay the zero-determinant mark alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[LL-2:0], det.zero};
        end
    end

    // Track beats in flight
    assign vld_next = {vld_reg[PL-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[PL-1];
        end
    end

    m3i_merge u_merge (
        .lane     (lane_res),
        .det_zero (zero_reg[LL-1]),
        .inv      (inv_next),
        .singular (sing_next),
        .overflow (ovf_next)
    );

    // Hold the merged result for the receiver
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg  <= inv_next;
            sing_reg <= sing_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign inv_r0c0  = inv_reg[0];
    assign inv_r0c1  = inv_reg[1];
    assign inv_r0c2  = inv_reg[2];
    assign inv_r1c0  = inv_reg[3];
    assign inv_r1c1  = inv_reg[4];
    assign inv_r1c2  = inv_reg[5];
    assign inv_r2c0  = inv_reg[6];
    assign inv_r2c1  = inv_reg[7];
    assign inv_r2c2  = inv_reg[8];
    assign singular  = sing_reg;
    assign overflow  = ovf_reg;

endmodule

// ===== hw/rtl/m3i_checker.sv =====
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks of the matrix inverse unit, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] inv_r0c0,
    input logic [15:0] inv_r1c1,
    input logic [15:0] inv_r2c2,
    input logic        singular,
    input logic        overflow
);

    // Singular results carry zeros on the diagonal
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> inv_r0c0 == '0 && inv_r1c1 == '0 && inv_r2c2 == '0)
        else $error("singular result with nonzero element");

    // Singular and overflow never together
    a_sing_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !overflow)
        else $error("overflow raised on singular result");

    // Empty output means the input side is open
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inv_r0c0) && $stable(singular))
        else $error("stalled result changed");

endmodule

bind matrix3x3_inverse_unit m3i_checker u_m3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .inv_r0c0  (inv_r0c0),
    .inv_r1c1  (inv_r1c1),
    .inv_r2c2  (inv_r2c2),
    .singular  (singular),
    .overflow  (overflow)
);

// ===== tb/sv/tb_matrix3x3_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse_unit
// Self-checking bench for the 3x3 fixed-point matrix inverse unit: directed
// matrices (identity, singular, saturating, rounding, field extremes), then
// random matrices, scored against a wide-integer adjugate inverse model.
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic signed [15:0] inv [9];
        logic               sing;
        logic               ovf;
    } inverse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] elem [9];
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] inv [9];
    logic singular, overflow;

    inverse_t expected_q[$];
    int  error_count = 0;
    int  idle_pct = 21;
    bit  stim_done = 1'b0;
    int  quiet_cycles = 0;

    initial
    begin
        foreach (elem[k]) elem[k] = '0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    matrix3x3_inverse_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .elem_r0c0(elem[0]), .elem_r0c1(elem[1]), .elem_r0c2(elem[2]),
        .elem_r1c0(elem[3]), .elem_r1c1(elem[4]), .elem_r1c2(elem[5]),
        .elem_r2c0(elem[6]), .elem_r2c1(elem[7]), .elem_r2c2(elem[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
        .inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
        .inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
        .singular(singular), .overflow(overflow)
    );

    // Exact adjugate / determinant, round half away from zero, saturate.
    function automatic inverse_t compute_inverse(logic signed [15:0] e [9]);
        inverse_t r;
        logic signed [127:0] m [3][3];
        logic signed [127:0] adj [3][3];
        logic signed [127:0] det, num;
        logic [127:0] dmag, nmag, q, rm;
        logic neg;
        int i1, i2, j1, j2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = e[i*3+j];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j + 1) % 3; j2 = (j + 2) % 3;
                i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                adj[i][j] = m[j1][i1] * m[j2][i2] - m[j1][i2] * m[j2][i1];
            end
        det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
        r.sing = (det == 0);
        r.ovf  = 1'b0;
        dmag = det < 0 ? -det : det;
        for (int k = 0; k < 9; k++)
        begin
            r.inv[k] = '0;
            if (!r.sing)
            begin
                num  = adj[k/3][k%3] <<< (2 * m3i_pkg::FRAC_BITS);
                neg  = (num < 0) != (det < 0);
                nmag = num < 0 ? -num : num;
                q  = nmag / dmag;
                rm = nmag % dmag;
                if ((rm << 1) >= dmag) q = q + 1;
                if (!neg && q > 32767)
                begin
                    r.ovf = 1'b1; r.inv[k] = 16'sh7FFF;
                end
                else if (neg && q > 32768)
                begin
                    r.ovf = 1'b1; r.inv[k] = 16'sh8000;
                end
                else
                    r.inv[k] = neg ? -q[15:0] : q[15:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Send one matrix beat with random idle before it.
    task automatic send_matrix(input logic signed [15:0] e [9]);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        elem = e;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_q.push_back(compute_inverse(e));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_q.size() != 0) @(negedge clk);
    endtask

    // Receiver stall pattern.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= idle_pct);

    // Score each result beat.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            inverse_t want;
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = expected_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (inv[k] !== want.inv[k])
                        report_mismatch($sformatf("inv[%0d]", k), inv[k], want.inv[k]);
                if (singular !== want.sing) report_mismatch("singular", singular, want.sing);
                if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
            end
        end
    end

    // Watchdog on handshake inactivity.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !stim_done)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return $signed(16'($urandom_range(8192))) - 16'sd4096;
            2: return $signed(16'($urandom_range(64))) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [15:0] e [9];
        // identity
        e = '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096}; send_matrix(e);
        // negative identity
        e = '{-4096, 0, 0, 0, -4096, 0, 0, 0, -4096}; send_matrix(e);
        // all zero: singular
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
        // repeated rows: singular
        e = '{100, 200, 300, 100, 200, 300, 7, 8, 9}; send_matrix(e);
        // tiny diagonal: saturation both signs
        e = '{1, 0, 0, 0, -1, 0, 0, 0, 1}; send_matrix(e);
        // extremes
        e = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767}; send_matrix(e);
        e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_matrix(e);
        e = '{-32768, 32767, -32768, 32767, -32768, 32767, 1, 2, -1}; send_matrix(e);
        e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_matrix(e);
        // rounding: diag 3.0, 2.0 and 6.0, then a 2.0/1.0 block, give inverse 1/3 and 2/3 cases
        e = '{12288, 0, 0, 0, 8192, 0, 0, 0, 24576}; send_matrix(e);
        e = '{3, 0, 0, 0, 8192, 4096, 0, 4096, 8192}; send_matrix(e);
        // inverse exactly -32768 vs just beyond it
        e = '{512, 0, 0, 0, -512, 0, 0, 0, 4096}; send_matrix(e);
        e = '{-511, 0, 0, 0, 511, 0, 0, 0, 4096}; send_matrix(e);
        e = '{16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA,
              16'shAAAA, 16'sh8000, 16'sh5555};
        send_matrix(e);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic signed [15:0] e [9];
        for (int n = 0; n < count; n++)
        begin
            idle_pct = (n >= 150 && n < 250) ? 0 : 21;
            foreach (e[k]) e[k] = rand_elem();
            if ($urandom_range(9) == 0)
            begin
                // copy a row so the determinant vanishes
                for (int c = 0; c < 3; c++) e[6+c] = e[c];
            end
            send_matrix(e);
            if (n == 300) wait_drained();
        end
        idle_pct = 21;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(540);
        wait_drained();
        stim_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Bound the final wait.
    initial
    begin
        wait (stim_done == 1'b0 && rst_n);
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
